/* hw/rtl/mandelbrot_escape_time_top_defines.svh */
// Assertion macros used by the checker module of the escape-time block.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH

// Antecedent holds, so the consequent must hold in the same cycle.
`define MANDEL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mandel check failed");

// Antecedent holds, so the consequent sequence must start in the next cycle.
`define MANDEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mandel check failed");

`endif

/* hw/rtl/mandel_pkg.sv */
// Types, widths and helper functions of the escape-time block.
// Depends on nothing; used by every module of the block.
package mandel_pkg;

   localparam int COORD_W   = 32;
   localparam int STEP_W    = 29;
   localparam int ITER_W    = 9;
   localparam int INDEX_W   = 10;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;
   localparam int FRAC_BITS = 28;
   localparam int SUM_W     = 41;

   localparam logic signed [COORD_W-1:0] ORIGIN_RE_RESET = -32'sd671088640;
   localparam logic signed [COORD_W-1:0] ORIGIN_IM_RESET = 32'sd335544320;
   localparam logic [STEP_W-1:0]         STEP_RESET      = 29'd1342177;
   localparam logic [ITER_W-1:0]         MAX_ITER_RESET  = 9'd256;

   // Four in the Q8.56 format of the squared magnitude.
   localparam logic [PROD_W-1:0] BOUND_Q56 = 64'h0400_0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_RE  = 2'd0,
      CSR_ORIGIN_IM  = 2'd1,
      CSR_PIXEL_STEP = 2'd2,
      CSR_MAX_ITER   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] column;
      logic [INDEX_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [ITER_W-1:0] iteration_count;
      logic              escaped;
   } rsp_type;

   // Saturates a wide signed sum to the signed Q4.28 range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (&v[SUM_W-1:COORD_W-1]) | ~(|v[SUM_W-1:COORD_W-1]);
      if (fits) begin
         return v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

/* hw/rtl/mandelbrot_escape_time_top.sv */
// Top level of the escape-time evaluator: register file, sequencer and datapath.
// Depends on mandel_pkg and the shared multiplier mandel_mul.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   req_type: column, row
//   rsp      out        rsp_valid/rsp_stall   rsp_type: iteration_count, escaped
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// A pixel is mapped onto c in MAP_RE, MAP_IM and LOAD; each bounded pass runs SQ_X,
// SQ_Y, CROSS and UPDATE, an escaping pass stops after CROSS, and FINISH loads the result
// word. The single multiplier forms x*x, y*y and x*y in turn for every pass.
// req_stall is high from acceptance until the result word is loaded.
// The result register lets a new word be accepted while the previous result is stalled.
// Reset restores the register reset values and empties the result register.
module mandelbrot_escape_time_top
   import mandel_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [INDEX_W-1:0] COL_LAST = INDEX_W'(MAX_COLUMNS - 1);
   localparam logic [INDEX_W-1:0] ROW_LAST = INDEX_W'(MAX_ROWS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_LOAD,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CROSS,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic signed [COORD_W-1:0] origin_re_ff, origin_im_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [ITER_W-1:0]         max_iter_ff;

   logic [INDEX_W-1:0]        col_ff, col_in, row_ff, row_in;
   logic signed [COORD_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [PROD_W-1:0]  x2_ff, x2_in, diff_ff, diff_in;
   logic [ITER_W-1:0]         count_ff, count_in;

   logic signed [COORD_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [COORD_W-1:0] map_coord;
   logic [PROD_W-1:0]         mag2;
   logic                      out_free;

   mandel_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= ORIGIN_RE_RESET;
         origin_im_ff <= ORIGIN_IM_RESET;
         step_ff      <= STEP_RESET;
         max_iter_ff  <= MAX_ITER_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_RE:  origin_re_ff <= csr_wdata;
            CSR_ORIGIN_IM:  origin_im_ff <= csr_wdata;
            CSR_PIXEL_STEP: step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER:   max_iter_ff  <= csr_wdata[ITER_W-1:0];
            default:        origin_re_ff <= origin_re_ff;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         ST_MAP_RE: begin
            mul_a = $signed({{(COORD_W-INDEX_W){1'b0}}, col_ff});
            mul_b = $signed({{(COORD_W-STEP_W){1'b0}}, step_ff});
         end
         ST_MAP_IM: begin
            mul_a = $signed({{(COORD_W-INDEX_W){1'b0}}, row_ff});
            mul_b = $signed({{(COORD_W-STEP_W){1'b0}}, step_ff});
         end
         ST_SQ_X: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_SQ_Y: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   always_comb begin
      logic signed [COORD_W-1:0] origin;
      origin    = (state_ff == ST_MAP_IM) ? origin_re_ff : origin_im_ff;
      map_coord = sat_coord(SUM_W'(origin) +
                            $signed({{(SUM_W-39){1'b0}}, prod[38:0]}));
      mag2      = x2_ff + prod;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x2_in        = x2_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               col_in   = ({22'd0, req_data.column} >= MAX_COLUMNS) ? COL_LAST
                                                                     : req_data.column;
               row_in   = ({22'd0, req_data.row} >= MAX_ROWS) ? ROW_LAST : req_data.row;
               state_in = ST_MAP_RE;
            end
         end
         ST_MAP_RE: begin
            state_in = ST_MAP_IM;
         end
         ST_MAP_IM: begin
            c_re_in  = map_coord;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            c_im_in  = map_coord;
            x_in     = c_re_ff;
            y_in     = map_coord;
            count_in = '0;
            state_in = (max_iter_ff != '0) ? ST_SQ_X : ST_FINISH;
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            x2_in    = prod;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            diff_in  = x2_ff - prod;
            state_in = (mag2 > BOUND_Q56) ? ST_FINISH : ST_UPDATE;
         end
         ST_UPDATE: begin
            x_in     = sat_coord(SUM_W'($signed(diff_ff[PROD_W-1:FRAC_BITS])) +
                                 SUM_W'(c_re_ff));
            y_in     = sat_coord(SUM_W'($signed(prod[PROD_W-1:FRAC_BITS-1])) +
                                 SUM_W'(c_im_ff));
            count_in = count_ff + 1'b1;
            state_in = (count_in < max_iter_ff) ? ST_SQ_X : ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iteration_count = count_ff;
               rsp_data_in.escaped         = (count_ff < max_iter_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      c_re_ff  <= c_re_in;
      c_im_ff  <= c_im_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      x2_ff    <= x2_in;
      diff_ff  <= diff_in;
      count_ff <= count_in;
   end

endmodule

/* hw/rtl/mandel_mul.sv */
// Shared 32 by 32 signed multiplier with a registered 64-bit product.
// Depends on mandel_pkg for the operand and product widths.
module mandel_mul
   import mandel_pkg::*;
(
   input  logic                      clock,
   input  logic signed [COORD_W-1:0] mul_a,
   input  logic signed [COORD_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hw/rtl/mandel_chk.sv */
// Port-level checker for the escape-time block and its bind to the top level.
// Depends on mandel_pkg and the macros in mandelbrot_escape_time_top_defines.svh.
`include "mandelbrot_escape_time_top_defines.svh"

module mandel_chk
   import mandel_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `MANDEL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `MANDEL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall ##1 req_stall ##1 req_stall)
   `MANDEL_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind mandelbrot_escape_time_top mandel_chk u_mandel_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* dv/mandelbrot_escape_time_top_tb.sv */
// Self-checking testbench for mandelbrot_escape_time_top: a directed table, then random phases.
// Each pixel word is scored against a typed table value or an escape-time predictor kept in step with the CSR writes.
// Depends on mandel_pkg and the mandelbrot_escape_time_top RTL only.
module mandelbrot_escape_time_top_tb;
   import mandel_pkg::*;

   localparam int MAX_COLUMNS     = 1024;
   localparam int MAX_ROWS        = 1024;
   localparam int ITEM_TARGET     = 1550;
   localparam int CYCLE_LIMIT     = 20000000;
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int TAIL_CYCLES     = 2100;

   typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_type;

   typedef struct {
      plan_kind_type      kind;
      csr_index_type      index;
      logic [CSR_W-1:0]   value;
      logic [INDEX_W-1:0] column;
      logic [INDEX_W-1:0] row;
      bit                 typed;
      logic [ITER_W-1:0]  count;
      logic               escaped;
   } plan_entry_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   logic signed [COORD_W-1:0] cfg_origin_re  = ORIGIN_RE_RESET;
   logic signed [COORD_W-1:0] cfg_origin_im  = ORIGIN_IM_RESET;
   logic [STEP_W-1:0]         cfg_pixel_step = STEP_RESET;
   logic [ITER_W-1:0]         cfg_max_iter   = MAX_ITER_RESET;

   rsp_type due_words[$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      cycles     = 0;
   bit      sender_idles   = 1'b1;
   bit      receiver_idles = 1'b1;
   bit      hold_rsp       = 1'b0;

   plan_entry_type plan [40] = '{
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b1, 9'd0,   1'b1},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1023, 10'd1023, 1'b1, 9'd0,   1'b1},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd512,  10'd250,  1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd350,  10'd250,  1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd300,  10'd200,  1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_IM,  32'h0, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_PIXEL_STEP, 32'h0, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b1, 9'd256, 1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1023, 10'd1023, 1'b1, 9'd256, 1'b0},
      '{PLAN_WRITE, CSR_MAX_ITER,   32'h0, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd517,  10'd3,    1'b1, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_MAX_ITER,   32'h1, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b1, 9'd1,   1'b0},
      '{PLAN_WRITE, CSR_MAX_ITER,   32'd511, 10'd0,  10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b1, 9'd511, 1'b0},
      '{PLAN_WRITE, CSR_MAX_ITER,   32'd256, 10'd0,  10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'hE000_0000, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1023, 10'd0,    1'b1, 9'd256, 1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'h2000_0000, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd1023, 1'b1, 9'd1,   1'b1},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_PIXEL_STEP, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1023, 10'd1023, 1'b1, 9'd0,   1'b1},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'h8000_0000, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_IM,  32'h8000_0000, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_PIXEL_STEP, 32'h1, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b1, 9'd0,   1'b1},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1023, 10'd1023, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_IM,  32'hFFFF_FFFD, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_PIXEL_STEP, 32'h7, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd0,    10'd0,    1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd1,    10'd2,    1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_RE,  32'(ORIGIN_RE_RESET), 10'd0, 10'd0, 1'b0, 9'd0, 1'b0},
      '{PLAN_WRITE, CSR_ORIGIN_IM,  32'(ORIGIN_IM_RESET), 10'd0, 10'd0, 1'b0, 9'd0, 1'b0},
      '{PLAN_WRITE, CSR_PIXEL_STEP, 32'(STEP_RESET), 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_WRITE, CSR_MAX_ITER,   32'hFFFF_FE28, 10'd0, 10'd0, 1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd350,  10'd250,  1'b0, 9'd0,   1'b0},
      '{PLAN_PIXEL, CSR_ORIGIN_RE,  32'h0, 10'd100,  10'd400,  1'b0, 9'd0,   1'b0}
   };

   mandelbrot_escape_time_top #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint clamp_q(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rsp_type escape_time(req_type w);
      longint            col, lin, c_re, c_im, x, y, x2, y2, xy;
      logic [PROD_W-1:0] r2;
      int unsigned       n, count;
      rsp_type           r;
      col = longint'(w.column);
      lin = longint'(w.row);
      if (col > MAX_COLUMNS - 1) begin
         col = longint'(MAX_COLUMNS - 1);
      end
      if (lin > MAX_ROWS - 1) begin
         lin = longint'(MAX_ROWS - 1);
      end
      c_re = clamp_q(longint'(cfg_origin_re) + col * longint'(cfg_pixel_step));
      c_im = clamp_q(longint'(cfg_origin_im) + lin * longint'(cfg_pixel_step));
      x = c_re;
      y = c_im;
      count = 0;
      for (n = 0; n < cfg_max_iter; n++) begin
         x2 = x * x;
         y2 = y * y;
         r2 = x2 + y2;
         if (r2 > BOUND_Q56) begin
            break;
         end
         xy = x * y;
         x = clamp_q(((x2 - y2) >>> FRAC_BITS) + c_re);
         y = clamp_q(((xy + xy) >>> FRAC_BITS) + c_im);
         count++;
      end
      r.iteration_count = ITER_W'(count);
      r.escaped         = (count < cfg_max_iter);
      return r;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_ORIGIN_RE:  cfg_origin_re  = v;
         CSR_ORIGIN_IM:  cfg_origin_im  = v;
         CSR_PIXEL_STEP: cfg_pixel_step = v[STEP_W-1:0];
         CSR_MAX_ITER:   cfg_max_iter   = v[ITER_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Leaves req_valid high on return unless an idle burst was taken.
   task automatic offer_pixel(req_type w, rsp_type due);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      due_words.push_back(due);
      items_sent++;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (due_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("mandelbrot_escape_time_top_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            due = due_words.pop_front();
            if (rsp_data.iteration_count !== due.iteration_count) begin
               $display("%0t: iteration_count expected %0d actual %0d", $time,
                        due.iteration_count, rsp_data.iteration_count);
               mismatches++;
            end
            if (rsp_data.escaped !== due.escaped) begin
               $display("%0t: escaped expected %0d actual %0d", $time,
                        due.escaped, rsp_data.escaped);
               mismatches++;
            end
         end
      end
   end

   initial begin : rsp_side
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      req_type          w;
      rsp_type          due;
      int               phase, k, phase_items, mode, iter_pick;
      int unsigned      max_iter;
      logic [CSR_W-1:0] v_re, v_im, v_step, v_iter;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_ORIGIN_RE;
      csr_wdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_WRITE) begin
            drain_results();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            w.column = plan[i].column;
            w.row    = plan[i].row;
            if (plan[i].typed) begin
               due.iteration_count = plan[i].count;
               due.escaped         = plan[i].escaped;
            end else begin
               due = escape_time(w);
            end
            offer_pixel(w, due);
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         drain_results();
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            v_re   = 32'(-671088640 + int'($urandom_range(0, 402653184)));
            v_im   = 32'(-402653184 + int'($urandom_range(0, 536870912)));
            v_step = $urandom;
            v_step[STEP_W-1:0] = STEP_W'($urandom_range(1 << 12, 1 << 21));
         end else if (mode < 8) begin
            v_re   = $urandom;
            v_im   = $urandom;
            v_step = $urandom;
         end else begin
            v_re   = 32'(-671088640 + int'($urandom_range(0, 805306368)));
            v_im   = 32'(-402653184 + int'($urandom_range(0, 805306368)));
            v_step = $urandom;
            v_step[STEP_W-1:0] = '0;
         end
         iter_pick = $urandom_range(0, 19);
         if (iter_pick < 14) begin
            max_iter = $urandom_range(1, 48);
         end else if (iter_pick < 17) begin
            max_iter = 256;
         end else if (iter_pick < 18) begin
            max_iter = 0;
         end else begin
            max_iter = $urandom_range(257, 511);
         end
         v_iter = $urandom;
         v_iter[ITER_W-1:0] = ITER_W'(max_iter);
         write_reg(CSR_ORIGIN_RE, v_re);
         write_reg(CSR_ORIGIN_IM, v_im);
         write_reg(CSR_PIXEL_STEP, v_step);
         write_reg(CSR_MAX_ITER, v_iter);

         if (items_sent >= ITEM_TARGET - 150) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         phase_items = (max_iter > 64) ? 12 : 60;

         for (k = 0; k < phase_items && items_sent < ITEM_TARGET; k++) begin
            if (phase == 3 && k == 8) begin
               hold_rsp = 1'b1;
            end
            if (phase == 6 && k == 20) begin
               drain_results();
            end
            w.column = INDEX_W'($urandom_range(0, 1023));
            w.row    = INDEX_W'($urandom_range(0, 1023));
            offer_pixel(w, escape_time(w));
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_words.size() == 0) begin
         $display("mandelbrot_escape_time_top_tb: clean");
      end else begin
         $display("mandelbrot_escape_time_top_tb: errors");
      end
      $finish;
   end

endmodule
